### hdl/slab_bitmap_address_allocator_assert.svh
// assertion macros for the slab bitmap address allocator
`ifndef SLAB_BITMAP_ADDRESS_ALLOCATOR_ASSERT_SVH
`define SLAB_BITMAP_ADDRESS_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked check, quiet while reset is high
`define SBAA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sbaa assertion failed");
// clocked check that also holds during reset
`define SBAA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("sbaa assertion failed");
`else
`define SBAA_ASSERT(lbl, clk, rst, prop)
`define SBAA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/sbaa_pkg.sv
// shared constants, codes and controller/datapath interface types
`default_nettype none
package sbaa_pkg;

   localparam int ADDR_BITS  = 39;
   localparam int SLAB_SHIFT = 21;
   localparam int SLAB_W     = ADDR_BITS - SLAB_SHIFT;   // slab index width
   localparam int EXT_W      = SLAB_W + 1;               // slab index plus headroom
   localparam int LEN_W      = 32;
   localparam int ALN_W      = LEN_W - SLAB_SHIFT + 1;   // length or alignment in slabs
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int WIDX_W     = SLAB_W - BIT_W;           // map word index width
   localparam int MAP_DEPTH  = 1 << WIDX_W;
   localparam int DCNT_W     = $clog2(EXT_W + 1);
   localparam int IN_DATA_W  = ((ADDR_BITS + 2 * LEN_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((ADDR_BITS + 7) / 8) * 8;

   localparam logic [EXT_W-1:0] SLAB_TOTAL = EXT_W'(1) << SLAB_W;
   localparam logic [EXT_W-1:0] TOP_SLAB   = SLAB_TOTAL - EXT_W'(1);

   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_EXCLUDE = 2'd2;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_start;
      logic div_sel;     // 0 aligned cursor, 1 try limit
      logic base_load;
      logic tries_load;
      logic cand_init;
      logic rng_init;
      logic rd;
      logic wr;
      logic wi_inc;
      logic set_bits;
      logic next_base;
      logic grant;
      logic fail;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       div_busy;
      logic       tries_left;
      logic       base_ok;
      logic       zero_count;
      logic       hit;
      logic       last_word;
      logic [1:0] func;
   } sts_type;

endpackage
`default_nettype wire

### hdl/sbaa_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module sbaa_div
   import sbaa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [EXT_W-1:0] dividend,
   input  wire logic [ALN_W-1:0] divisor,
   output logic                  busy,
   output logic [EXT_W-1:0]      quotient
);

   logic [EXT_W-1:0]  quo_ff, quo_in;
   logic [ALN_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [ALN_W:0]    trial;
   logic [ALN_W+1:0]  diff;

   always_comb begin
      trial  = {rem_ff, quo_ff[EXT_W-1]};
      diff   = {1'b0, trial} - {2'b00, divisor};
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DCNT_W'(EXT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[ALN_W+1]) begin
            rem_in = trial[ALN_W-1:0];
            quo_in = {quo_ff[EXT_W-2:0], 1'b0};
         end else begin
            rem_in = diff[ALN_W-1:0];
            quo_in = {quo_ff[EXT_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### hdl/sbaa_dp.sv
// datapath: used-slab map, cursor, candidate base, word masks and result registers
`default_nettype none
module sbaa_dp
   import sbaa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [1:0]            req_tuser,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   output logic                       rsp_tuser,
   output logic [OUT_DATA_W-1:0]      rsp_tdata
);

   logic [WORD_W-1:0] map_mem [MAP_DEPTH];

   logic [1:0]          func_ff;
   logic [SLAB_W-1:0]   rng_first_ff;
   logic [ALN_W-1:0]    count_ff, align_ff;
   logic [SLAB_W-1:0]   cursor_ff;
   logic [EXT_W-1:0]    base_ff, tries_ff, t_ff, end_ff;
   logic [SLAB_W-1:0]   first_ff;
   logic [WIDX_W-1:0]   wi_ff, clr_ff;
   logic [WORD_W-1:0]   rd_data_ff;
   logic                res_status_ff, out_status_ff;
   logic [ADDR_BITS-1:0] res_grant_ff, out_grant_ff;

   logic [LEN_W:0]      len_sum, aln_sum;
   logic [ALN_W-1:0]    count_in, align_in;
   logic [EXT_W-1:0]    div_dividend, div_q, end_m1, rng_sum, rng_end;
   logic                div_busy;
   logic [EXT_W:0]      bc_sum, nb_sum;
   logic [BIT_W-1:0]    lo_bit, hi_bit;
   logic [WORD_W-1:0]   mask;
   logic                last_word;
   logic [ALN_W+EXT_W-1:0] prod;

   // input rounding to whole slabs
   always_comb begin
      len_sum  = {1'b0, req_tdata[ADDR_BITS+LEN_W-1:ADDR_BITS]}
                 + (LEN_W+1)'((1 << SLAB_SHIFT) - 1);
      aln_sum  = {1'b0, req_tdata[ADDR_BITS+2*LEN_W-1:ADDR_BITS+LEN_W]}
                 + (LEN_W+1)'((1 << SLAB_SHIFT) - 1);
      count_in = len_sum[LEN_W:SLAB_SHIFT];
      align_in = aln_sum[LEN_W:SLAB_SHIFT];
      if (align_in == '0) begin
         align_in = ALN_W'(1);
      end
   end

   assign div_dividend = cmd.div_sel ? TOP_SLAB
                       : ({1'b0, cursor_ff} + EXT_W'(align_ff) - EXT_W'(1));

   sbaa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (align_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      prod    = div_q * align_ff;
      bc_sum  = {1'b0, base_ff} + (EXT_W+1)'(count_ff);
      nb_sum  = {1'b0, base_ff} + (EXT_W+1)'(align_ff);
      rng_sum = {1'b0, rng_first_ff} + EXT_W'(count_ff);
      rng_end = (rng_sum > SLAB_TOTAL) ? SLAB_TOTAL : rng_sum;
      end_m1  = end_ff - EXT_W'(1);
      last_word = (wi_ff == end_m1[SLAB_W-1:BIT_W]);
      lo_bit  = (wi_ff == first_ff[SLAB_W-1:BIT_W]) ? first_ff[BIT_W-1:0] : '0;
      hi_bit  = last_word ? end_m1[BIT_W-1:0] : '1;
      mask    = ({WORD_W{1'b1}} << lo_bit)
              & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= SLAB_W'(1);
         clr_ff    <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + WIDX_W'(1);
         end
         if (cmd.grant) begin
            cursor_ff <= (bc_sum > (EXT_W+1)'(TOP_SLAB)) ? SLAB_W'(1)
                                                         : bc_sum[SLAB_W-1:0];
         end
      end
      if (cmd.load) begin
         func_ff       <= req_tuser;
         rng_first_ff  <= req_tdata[ADDR_BITS-1:SLAB_SHIFT];
         count_ff      <= count_in;
         align_ff      <= align_in;
         res_status_ff <= 1'b0;
         res_grant_ff  <= '0;
      end
      if (cmd.base_load) begin
         base_ff <= prod[EXT_W-1:0];
      end
      if (cmd.tries_load) begin
         tries_ff <= div_q;
         t_ff     <= '0;
      end
      if (cmd.next_base) begin
         base_ff <= (nb_sum > (EXT_W+1)'(TOP_SLAB)) ? EXT_W'(align_ff)
                                                    : nb_sum[EXT_W-1:0];
         t_ff    <= t_ff + EXT_W'(1);
      end
      if (cmd.cand_init) begin
         first_ff <= base_ff[SLAB_W-1:0];
         end_ff   <= bc_sum[EXT_W-1:0];
         wi_ff    <= base_ff[SLAB_W-1:BIT_W];
      end
      if (cmd.rng_init) begin
         first_ff <= rng_first_ff;
         end_ff   <= rng_end;
         wi_ff    <= rng_first_ff[SLAB_W-1:BIT_W];
      end
      if (cmd.wi_inc) begin
         wi_ff <= wi_ff + WIDX_W'(1);
      end
      if (cmd.grant) begin
         res_status_ff <= 1'b0;
         res_grant_ff  <= {base_ff[SLAB_W-1:0], {SLAB_SHIFT{1'b0}}};
      end
      if (cmd.fail) begin
         res_status_ff <= 1'b1;
         res_grant_ff  <= '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_grant_ff  <= res_grant_ff;
      end
   end

   // used-slab map, one port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         map_mem[clr_ff] <= '0;
      end else if (cmd.wr) begin
         map_mem[wi_ff] <= cmd.set_bits ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
      end
      if (cmd.rd) begin
         rd_data_ff <= map_mem[wi_ff];
      end
   end

   always_comb begin
      sts.clr_last   = &clr_ff;
      sts.div_busy   = div_busy;
      sts.tries_left = (t_ff < tries_ff);
      sts.base_ok    = (bc_sum <= (EXT_W+1)'(SLAB_TOTAL));
      sts.zero_count = (count_ff == '0);
      sts.hit        = |(rd_data_ff & mask);
      sts.last_word  = last_word;
      sts.func       = func_ff;
   end

   assign rsp_tuser = out_status_ff;
   assign rsp_tdata = OUT_DATA_W'(out_grant_ff);

endmodule
`default_nettype wire

### hdl/sbaa_ctrl.sv
// controller state machine: clearing pass, candidate search, claim and range updates
`default_nettype none
`include "slab_bitmap_address_allocator_assert.svh"
module sbaa_ctrl
   import sbaa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_DIVB_GO, ST_DIVB_WAIT, ST_DIVT_GO, ST_DIVT_WAIT,
      ST_CAND, ST_SCAN_RD, ST_SCAN_EV, ST_CLM_RD, ST_CLM_WR,
      ST_RNG_INIT, ST_RNG_RD, ST_RNG_WR, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // func is registered by now
            state_in = ST_DONE;
            if (sts.func == FUNC_ALLOC) state_in = ST_DIVB_GO;
            if (sts.func == FUNC_RELEASE || sts.func == FUNC_EXCLUDE) begin
               state_in = ST_RNG_INIT;
            end
         end
         ST_DIVB_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVB_WAIT;
         end
         ST_DIVB_WAIT: begin
            if (!sts.div_busy) begin
               cmd.base_load = 1'b1;
               state_in      = ST_DIVT_GO;
            end
         end
         ST_DIVT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = ST_DIVT_WAIT;
         end
         ST_DIVT_WAIT: begin
            if (!sts.div_busy) begin
               cmd.tries_load = 1'b1;
               state_in       = ST_CAND;
            end
         end
         ST_CAND: begin
            if (!sts.tries_left) begin
               cmd.fail = 1'b1;
               state_in = ST_DONE;
            end else if (!sts.base_ok) begin
               cmd.next_base = 1'b1;
            end else if (sts.zero_count) begin
               cmd.grant = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.cand_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (sts.hit) begin
               cmd.next_base = 1'b1;
               state_in      = ST_CAND;
            end else if (sts.last_word) begin
               cmd.cand_init = 1'b1;
               state_in      = ST_CLM_RD;
            end else begin
               cmd.wi_inc = 1'b1;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_CLM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_CLM_WR;
         end
         ST_CLM_WR: begin
            cmd.wr       = 1'b1;
            cmd.set_bits = 1'b1;
            if (sts.last_word) begin
               cmd.grant = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.wi_inc = 1'b1;
               state_in   = ST_CLM_RD;
            end
         end
         ST_RNG_INIT: begin
            if (sts.zero_count) begin
               state_in = ST_DONE;
            end else begin
               cmd.rng_init = 1'b1;
               state_in     = ST_RNG_RD;
            end
         end
         ST_RNG_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_RNG_WR;
         end
         ST_RNG_WR: begin
            cmd.wr       = 1'b1;
            cmd.set_bits = (sts.func == FUNC_EXCLUDE);
            if (sts.last_word) begin
               state_in = ST_DONE;
            end else begin
               cmd.wi_inc = 1'b1;
               state_in   = ST_RNG_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SBAA_ASSERT(a_wr_follows_rd, clock, reset, cmd.wr |-> $past(cmd.rd))
   `SBAA_ASSERT(a_div_idle_on_start, clock, reset, cmd.div_start |-> !sts.div_busy)
   `SBAA_ASSERT(a_out_slot_free, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
   `SBAA_ASSERT(a_rsp_from_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.out_load))
   `SBAA_ASSERT_ALWAYS(a_no_clear_and_load, clock, !(cmd.clr_step && cmd.load))

endmodule
`default_nettype wire

### hdl/slab_bitmap_address_allocator.sv
// top level: next-fit slab allocator over a used-slab bitmap
// reset: synchronous; a clearing pass then zeroes the 8192-word map, no beat taken
// release/exclude: a read and a write per 32-slab map word touched; unknown func: straight to the result
// allocate: accept, decode and two divisions (aligned cursor, try limit), then per candidate base
//   a check plus a read and a compare per map word scanned, then a read and a write per word claimed
// one item in flight; the next beat is taken while a finished result waits in the output register
`default_nettype none
module slab_bitmap_address_allocator
   import sbaa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_tuser,   // func
   input  wire logic [IN_DATA_W-1:0]  req_tdata,   // base_address, length_bytes, align_bytes
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tuser,   // status
   output logic [OUT_DATA_W-1:0]      rsp_tdata    // granted_address
);

   cmd_type cmd;
   sts_type sts;

   // sequencing of the search, claim and range loops
   sbaa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // map memory, divider, cursor and result registers
   sbaa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

### dv/tb_slab_bitmap_address_allocator.sv
// self-checking testbench for the slab bitmap address allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_slab_bitmap_address_allocator
   import sbaa_pkg::*;
();

   // geometry of the slab space, worked out from the package widths
   localparam longint unsigned SLAB_BYTES = 64'd1 << SLAB_SHIFT;
   localparam longint unsigned SLAB_COUNT = 64'd1 << SLAB_W;
   localparam longint unsigned TOP_ADDR   = (64'd1 << ADDR_BITS) - SLAB_BYTES;
   localparam int              STALL_LIMIT = 40000000;

   typedef struct {
      logic [1:0]            func;
      logic [ADDR_BITS-1:0]  base;
      logic [LEN_W-1:0]      len;
      logic [LEN_W-1:0]      align;
   } req_item_type;

   typedef struct {
      logic                  status;
      logic [ADDR_BITS-1:0]  grant;
   } rsp_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;   // func
   logic [IN_DATA_W-1:0]  req_tdata;   // base_address, length_bytes, align_bytes
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  rsp_tuser;   // status
   logic [OUT_DATA_W-1:0] rsp_tdata;   // granted_address

   slab_bitmap_address_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow copy of the allocator state
   bit              shadow_used [SLAB_COUNT];
   longint unsigned shadow_cursor;
   longint unsigned shadow_used_cnt;

   req_item_type pending_beats[$];
   rsp_item_type expected_grants[$];

   // granted ranges that random releases can hand back
   longint unsigned live_base[$];
   longint unsigned live_len[$];

   int errors, n_alloc, n_fail, n_release, n_exclude, n_done;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint unsigned slabs_in(longint unsigned bytes);
      return (bytes + SLAB_BYTES - 1) >> SLAB_SHIFT;
   endfunction

   // mark or clear slabs, dropping those past the last one
   function automatic void mark_slabs(longint unsigned first, longint unsigned cnt, bit used);
      longint unsigned i;
      for (i = 0; i < cnt && first + i < SLAB_COUNT; i++) begin
         if (shadow_used[first + i] != used)
            shadow_used_cnt = used ? shadow_used_cnt + 1 : shadow_used_cnt - 1;
         shadow_used[first + i] = used;
      end
   endfunction

   // all-or-none claim of cnt slabs at base
   function automatic bit claim_at(longint unsigned base, longint unsigned cnt);
      longint unsigned first, i;
      first = base >> SLAB_SHIFT;
      if (first > SLAB_COUNT || cnt > SLAB_COUNT - first)
         return 1'b0;
      for (i = 0; i < cnt; i++)
         if (shadow_used[first + i])
            return 1'b0;
      mark_slabs(first, cnt, 1'b1);
      return 1'b1;
   endfunction

   // next-fit search or range update, returns the expected response beat
   function automatic rsp_item_type allocator_result(req_item_type it);
      rsp_item_type    r;
      longint unsigned cnt, aln, base, tries, t, first;
      r.status = 1'b0;
      r.grant  = '0;
      cnt = slabs_in(it.len);
      first = (longint'(it.base) >> SLAB_SHIFT) & (SLAB_COUNT - 1);
      case (it.func)
         FUNC_ALLOC: begin
            aln = slabs_in(it.align) << SLAB_SHIFT;
            if (aln == 0)
               aln = SLAB_BYTES;
            base  = ((shadow_cursor + aln - 1) / aln) * aln;
            tries = TOP_ADDR / aln;
            r.status = 1'b1;
            for (t = 0; t < tries; t++) begin
               if (claim_at(base, cnt)) begin
                  r.status = 1'b0;
                  r.grant  = base[ADDR_BITS-1:0];
                  shadow_cursor = base + (cnt << SLAB_SHIFT);
                  // cursor wraps back to slab 1 once it runs past the top
                  if (shadow_cursor > TOP_ADDR)
                     shadow_cursor = SLAB_BYTES;
                  break;
               end
               base += aln;
               if (base > TOP_ADDR)
                  base = aln;
            end
         end
         FUNC_RELEASE: mark_slabs(first, cnt, 1'b0);
         FUNC_EXCLUDE: mark_slabs(first, cnt, 1'b1);
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit cnt_nonzero(logic [LEN_W-1:0] l);
      return l != 0;
   endfunction

   task automatic queue_beat(logic [1:0] f, longint unsigned b, longint unsigned l,
                             longint unsigned a);
      req_item_type it;
      rsp_item_type r;
      it.func  = f;
      it.base  = b[ADDR_BITS-1:0];
      it.len   = l[LEN_W-1:0];
      it.align = a[LEN_W-1:0];
      r = allocator_result(it);
      if (f == FUNC_ALLOC && !r.status && cnt_nonzero(it.len)) begin
         live_base.push_back(r.grant);
         live_len.push_back(it.len);
      end
      pending_beats.push_back(it);
      expected_grants.push_back(r);
   endtask

   // stimulus: directed corners, a fill-to-full phase, then random traffic
   initial begin
      longint unsigned b, l, a;
      int k, sel, pick;
      shadow_cursor = SLAB_BYTES;
      shadow_used_cnt = 0;

      queue_beat(FUNC_ALLOC, 0, 0, 0);                     // zero length, zero alignment
      queue_beat(FUNC_ALLOC, '1, 1, 0);                    // base ignored on allocate
      queue_beat(FUNC_ALLOC, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(FUNC_ALLOC, 0, 3 * SLAB_BYTES, 3 * SLAB_BYTES);  // non power of two align
      queue_beat(FUNC_ALLOC, 0, SLAB_BYTES + 1, SLAB_BYTES - 1);
      queue_beat(FUNC_EXCLUDE, TOP_ADDR, 4 * SLAB_BYTES, 0);     // runs past the top
      queue_beat(FUNC_ALLOC, 0, SLAB_BYTES, 32'h8000_0000);
      queue_beat(FUNC_RELEASE, TOP_ADDR, 4 * SLAB_BYTES, 0);
      queue_beat(FUNC_RELEASE, 64'h7F_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(FUNC_EXCLUDE, 0, 0, 0);
      queue_beat(2'd3, 64'h7F_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unknown func
      queue_beat(FUNC_EXCLUDE, 5 * SLAB_BYTES + 7, 1, 0);
      queue_beat(FUNC_ALLOC, 0, 2 * SLAB_BYTES, SLAB_BYTES);

      // fill the whole map, show no_space and zero-length grant, then empty it
      for (k = 0; k < 128; k++)
         queue_beat(FUNC_EXCLUDE, longint'(k) << 32, 32'hFFFF_FFFF, 0);
      queue_beat(FUNC_ALLOC, 0, 1, 32'h8000_0000);
      queue_beat(FUNC_ALLOC, 0, 0, 32'h8000_0000);
      for (k = 0; k < 128; k++)
         queue_beat(FUNC_RELEASE, longint'(k) << 32, 32'hFFFF_FFFF, 0);
      live_base.delete();
      live_len.delete();

      for (k = 0; k < 180; k++) begin
         sel = $urandom_range(0, 99);
         if (shadow_used_cnt > 40000) begin
            // keep the map sparse so allocate searches stay short
            b = longint'($urandom_range(0, 127)) << 32;
            queue_beat(FUNC_RELEASE, b, 32'hFFFF_FFFF, $urandom);
         end else if (sel < 50) begin
            l = ($urandom_range(0, 9) == 0) ? $urandom
                : $urandom_range(0, 40) * SLAB_BYTES + $urandom_range(0, 1) * $urandom_range(1, 4095);
            a = ($urandom_range(0, 9) == 0) ? $urandom
                : $urandom_range(0, 8) * SLAB_BYTES - $urandom_range(0, 1);
            queue_beat(FUNC_ALLOC, {$urandom, $urandom}, l, a);
         end else if (sel < 80 && live_base.size() > 0) begin
            pick = $urandom_range(0, live_base.size() - 1);
            queue_beat(FUNC_RELEASE, live_base[pick] | $urandom_range(0, SLAB_BYTES - 1),
                       live_len[pick], $urandom);
            live_base.delete(pick);
            live_len.delete(pick);
         end else if (sel < 95) begin
            b = {$urandom, $urandom};
            queue_beat(sel < 90 ? FUNC_EXCLUDE : FUNC_RELEASE, b,
                       $urandom_range(0, 16 * SLAB_BYTES), $urandom);
         end else begin
            queue_beat(2'd3, {$urandom, $urandom}, $urandom, $urandom);
         end
      end

      wait (pending_beats.size() == 0 && !req_tvalid);
      wait (expected_grants.size() == 0);
      repeat (50) @(posedge clock);
      $display("covered %0d allocates (%0d no_space), %0d releases, %0d excludes",
               n_alloc, n_fail, n_release, n_exclude);
      $display("%0d response beats checked, %0d mismatches", n_done, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // reset held high at the start, then released
   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts of beats separated by random gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= '0;
         req_tdata  <= '0;
         burst_left <= $urandom_range(1, 12);
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_item_type it;
            it = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.func;
            req_tdata  <= {{(IN_DATA_W - ADDR_BITS - 2 * LEN_W){1'b0}},
                           it.align, it.len, it.base};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else
               burst_left <= burst_left - 1;
         end else
            req_tvalid <= 1'b0;
      end
   end

   // receiver stall pattern: alternates free-running and choppy windows
   int rsp_cycle;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_cycle  <= 0;
      end else begin
         rsp_cycle  <= rsp_cycle + 1;
         rsp_tready <= rsp_cycle[9] ? 1'b1 : (($urandom_range(0, 2) != 0) && rsp_cycle[2:0] != 3'd5);
      end
   end

   // monitor: every response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         case (req_tuser)
            FUNC_ALLOC:   n_alloc++;
            FUNC_RELEASE: n_release++;
            FUNC_EXCLUDE: n_exclude++;
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_item_type e;
         n_done++;
         if (expected_grants.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat status=%0d addr=%h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            e = expected_grants.pop_front();
            if (e.status) n_fail++;
            if (rsp_tuser !== e.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_tuser);
            end
            if (rsp_tdata !== OUT_DATA_W'(e.grant)) begin
               errors++;
               $display("%0t: granted_address expected %h actual %h",
                        $time, e.grant, rsp_tdata);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses outstanding",
                  $time, expected_grants.size());
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
`default_nettype wire

### files.f
+incdir+hdl
hdl/sbaa_pkg.sv
hdl/sbaa_div.sv
hdl/sbaa_dp.sv
hdl/sbaa_ctrl.sv
hdl/slab_bitmap_address_allocator.sv
dv/tb_slab_bitmap_address_allocator.sv
